// ===== design/assert_macros.svh =====
// Assertion macros used by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== design/spdo_pkg.sv =====
`timescale 1ns / 1ps

package spdo_pkg;

  // Window of pulse differences used for the speed estimate.
  localparam int WINDOW_TICKS = 10;
  localparam int SLOT_W = $clog2(WINDOW_TICKS);
  localparam int SUM_W = 16 + $clog2(WINDOW_TICKS);

  // Divider operand widths.
  localparam int PROD_W = SUM_W + 12;
  localparam int NUM_W = PROD_W + 5;
  localparam int DEN_W = 20;
  localparam int STEP_W = $clog2(NUM_W + 1);

  // Distance steps in pulses.
  localparam logic [16:0] TRIP_STEP = 17'd280;
  localparam logic [16:0] ODO_STEP = 17'd2800;
  localparam logic [11:0] DEN_SCALE = 12'd2500;

  // Reciprocals for the constant divisions. The trip count divides by 8 and then by 35,
  // the odometer by 16 and then by 175, the map by 2 or 4 and then by 5. Each reciprocal
  // is rounded up and is exact over the operand range that reaches it.
  localparam logic [14:0] TRIP_RECIP = 15'd29960;
  localparam logic [12:0] ODO_RECIP = 13'd5992;
  localparam logic [19:0] FIFTH_RECIP = 20'd838861;

  // Indicated-speed map.
  localparam logic [7:0] MAP_X [9] = '{8'd0, 8'd10, 8'd20, 8'd40, 8'd60, 8'd80, 8'd100,
                                        8'd120, 8'd140};
  localparam logic [7:0] MAP_Y [9] = '{8'd0, 8'd10, 8'd21, 8'd42, 8'd63, 8'd84, 8'd106,
                                        8'd126, 8'd150};
  localparam logic [7:0] SPEED_MAX = 8'd199;
  localparam logic [7:0] TOP_X = 8'd140;
  localparam logic [7:0] TOP_Y = 8'd150;
  localparam logic [4:0] TOP_DY = 5'd24;
  localparam logic [4:0] TOP_DX = 5'd20;
  localparam logic [15:0] MPH_FACTOR = 16'd40722;

  // Configuration register indexes.
  localparam logic [2:0] REG_PPR = 3'd0;
  localparam logic [2:0] REG_PERIM = 3'd1;
  localparam logic [2:0] REG_IMPERIAL = 3'd2;
  localparam logic [2:0] REG_TRIP_LIMIT = 3'd3;
  localparam logic [2:0] REG_ODO_LIMIT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIST, ST_DIST_COMMIT, ST_MUL,
    ST_RAW_GO, ST_RAW_WAIT, ST_MAP_GO, ST_MAP_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic calc_dist;
    logic commit_dist;
    logic load_prod;
    logic div_start;
    logic commit_raw;
    logic load_map;
    logic commit_map;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic den_zero;
    logic raw_small;
    logic out_blocked;
  } sts_t;

  typedef struct packed {
    logic [7:0] x0;
    logic [7:0] y0;
    logic [4:0] dx;
    logic [4:0] dy;
  } seg_t;

  // Map segment for a speed below the top point.
  function automatic seg_t map_segment(input logic [15:0] x);
    seg_t s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      if (x >= 16'(MAP_X[i]) && x < 16'(MAP_X[i+1])) begin
        s.x0 = MAP_X[i];
        s.y0 = MAP_Y[i];
        s.dx = 5'(MAP_X[i+1] - MAP_X[i]);
        s.dy = 5'(MAP_Y[i+1] - MAP_Y[i]);
      end
    end
    return s;
  endfunction

endpackage

// ===== design/spdo_div.sv =====
`timescale 1ns / 1ps

module spdo_div import spdo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] steps_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [NUM_W-1:0]  quo_o
);

  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              done_q;
  logic [NUM_W-1:0]  num_q, quo_q;
  logic [DEN_W-1:0]  den_q, rem_q;
  logic [DEN_W:0]    trial;
  logic              ge;

  // One restoring step: bring down the next numerator bit and try to subtract.
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge = trial >= {1'b0, den_q};
  assign cnt_d = start_i ? steps_i : ((cnt_q != '0) ? cnt_q - 1'b1 : cnt_q);

  // Step counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= !start_i && (cnt_q == STEP_W'(1));
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = cnt_q != '0;
  assign done_o = done_q;
  assign quo_o = quo_q;

endmodule

// ===== design/spdo_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spdo_ctrl import spdo_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencing of the distance updates, the speed division and the map.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DIST;
        end
      end
      ST_DIST: begin
        cmd_o.calc_dist = 1'b1;
        state_d = ST_DIST_COMMIT;
      end
      ST_DIST_COMMIT: begin
        cmd_o.commit_dist = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.load_prod = 1'b1;
        state_d = ST_RAW_GO;
      end
      ST_RAW_GO: begin
        if (sts_i.den_zero) begin
          cmd_o.commit_raw = 1'b1;
          state_d = ST_MAP_GO;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_RAW_WAIT;
        end
      end
      ST_RAW_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.commit_raw = 1'b1;
          state_d = ST_MAP_GO;
        end
      end
      ST_MAP_GO: begin
        if (sts_i.raw_small) begin
          cmd_o.commit_map = 1'b1;
          state_d = ST_OUT;
        end else begin
          cmd_o.load_map = 1'b1;
          state_d = ST_MAP_WAIT;
        end
      end
      ST_MAP_WAIT: begin
        cmd_o.commit_map = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_blocked) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMP(a_start_idle_div, cmd_o.div_start, !sts_i.div_busy)
  `ASSERT_IMP(a_load_free_out, cmd_o.out_load, !sts_i.out_blocked)
  `ASSERT_NXT(a_start_busy, cmd_o.div_start, sts_i.div_busy)

endmodule

// ===== design/spdo_datapath.sv =====
`timescale 1ns / 1ps

module spdo_datapath import spdo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic [15:0] pulse_total_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  shown_speed_o,
  output logic [7:0]  metric_speed_o,
  output logic [15:0] trip_tenths_o,
  output logic [23:0] odo_km_o,
  output logic        save_strobe_o
);

  logic [7:0]  ppr_q;
  logic [11:0] perim_q;
  logic        imperial_q;
  logic [15:0] trip_limit_q;
  logic [23:0] odo_limit_q;

  logic [15:0]       prev_q;
  logic [15:0]       win_q [WINDOW_TICKS];
  logic [SLOT_W-1:0] slot_q;
  logic [SUM_W-1:0]  wsum_q;
  logic [8:0]        trip_rem_q;
  logic [11:0]       odo_rem_q;
  logic [16:0]       trip_acc_q, odo_acc_q;
  logic [8:0]        trip_quo_q;
  logic [5:0]        odo_quo_q;
  logic [15:0]       trip_q;
  logic [23:0]       odo_q;
  logic              save_q;
  logic [PROD_W-1:0] prod_q;
  logic [DEN_W-1:0]  den_q;
  logic [15:0]       raw_q;
  logic [20:0]       map_num_q;
  logic              map_wide_q;
  logic [7:0]        metric_q;
  logic [7:0]        seg_base_q;
  logic              out_valid_q;

  logic [15:0]       diff;
  logic [NUM_W-1:0]  raw_num;
  logic [NUM_W-1:0]  quo;
  logic              div_busy, div_done;
  seg_t              seg;
  logic              top_seg;
  logic [20:0]       map_num;
  logic [28:0]       trip_prod;
  logic [25:0]       odo_prod;
  logic [16:0]       trip_left, odo_left;
  logic [17:0]       trip_sum;
  logic [24:0]       odo_sum;
  logic [19:0]       map_n;
  logic [41:0]       map_prod;
  logic [19:0]       map_quo;
  logic [20:0]       map_val;
  logic [23:0]       mph_prod;

  assign diff = pulse_total_i - prev_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= 8'd1;
      perim_q <= 12'd2000;
      imperial_q <= 1'b0;
      trip_limit_q <= 16'd9999;
      odo_limit_q <= 24'd999999;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_PPR:        ppr_q <= cfg_data_i[7:0];
        REG_PERIM:      perim_q <= cfg_data_i[11:0];
        REG_IMPERIAL:   imperial_q <= cfg_data_i[0];
        REG_TRIP_LIMIT: trip_limit_q <= cfg_data_i[15:0];
        REG_ODO_LIMIT:  odo_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Map segment for the raw speed.
  assign top_seg = raw_q >= 16'(TOP_X);
  assign seg = map_segment(raw_q);
  always_comb begin
    if (top_seg) begin
      map_num = 21'((raw_q - 16'(TOP_X)) * TOP_DY) + 21'(TOP_DX >> 1);
    end else begin
      map_num = 21'((raw_q - 16'(seg.x0)) * seg.dy) + 21'(seg.dx >> 1);
    end
  end

  // Map division by 10 or 20: a shift, then a reciprocal multiplication by a fifth.
  assign map_n = map_wide_q ? {1'b0, map_num_q[20:2]} : map_num_q[20:1];
  assign map_prod = 42'(map_n) * 42'(FIFTH_RECIP);
  assign map_quo = map_prod[41:22];
  assign map_val = 21'(seg_base_q) + 21'(map_quo);

  // Distance quotients by reciprocal multiplication, remainders by subtraction.
  assign trip_prod = 29'(trip_acc_q[16:3]) * 29'(TRIP_RECIP);
  assign odo_prod = 26'(odo_acc_q[16:4]) * 26'(ODO_RECIP);
  assign trip_left = trip_acc_q - 17'(trip_quo_q) * TRIP_STEP;
  assign odo_left = odo_acc_q - 17'(odo_quo_q) * ODO_STEP;
  assign trip_sum = 18'(trip_q) + 18'(trip_quo_q);
  assign odo_sum = 25'(odo_q) + 25'(odo_quo_q);

  // Speed division operand: the product times nine plus half the divisor, for rounding.
  assign raw_num = NUM_W'({prod_q, 3'b000}) + NUM_W'(prod_q) + NUM_W'(den_q >> 1);

  spdo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .steps_i (STEP_W'(NUM_W)),
    .num_i   (raw_num),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Item state: previous sample, window, distance counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      for (int i = 0; i < WINDOW_TICKS; i++) begin
        win_q[i] <= '0;
      end
      slot_q <= '0;
      wsum_q <= '0;
      trip_rem_q <= '0;
      odo_rem_q <= '0;
      trip_q <= '0;
      odo_q <= '0;
    end else begin
      if (cmd_i.load_item) begin
        prev_q <= pulse_total_i;
        win_q[slot_q] <= diff;
        wsum_q <= wsum_q - SUM_W'(win_q[slot_q]) + SUM_W'(diff);
        slot_q <= (slot_q == SLOT_W'(WINDOW_TICKS - 1)) ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.commit_dist) begin
        trip_rem_q <= trip_left[8:0];
        odo_rem_q <= odo_left[11:0];
        if (trip_acc_q >= TRIP_STEP) begin
          trip_q <= (trip_sum > 18'(trip_limit_q)) ? '0 : trip_sum[15:0];
        end
        if (odo_acc_q >= ODO_STEP && odo_q < odo_limit_q) begin
          odo_q <= (odo_sum > 25'(odo_limit_q)) ? odo_limit_q : odo_sum[23:0];
        end
      end
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      trip_acc_q <= 17'(trip_rem_q) + 17'(diff);
      odo_acc_q <= 17'(odo_rem_q) + 17'(diff);
    end
    if (cmd_i.calc_dist) begin
      trip_quo_q <= trip_prod[28:20];
      odo_quo_q <= odo_prod[25:20];
    end
    if (cmd_i.commit_dist) begin
      save_q <= trip_acc_q >= TRIP_STEP;
    end
    if (cmd_i.load_prod) begin
      prod_q <= PROD_W'(wsum_q * perim_q);
      den_q <= DEN_W'(ppr_q * DEN_SCALE);
    end
    if (cmd_i.commit_raw) begin
      if (sts_o.den_zero) begin
        raw_q <= '0;
      end else begin
        raw_q <= (quo[NUM_W-1:16] != '0) ? 16'hFFFF : quo[15:0];
      end
    end
    if (cmd_i.load_map) begin
      map_num_q <= map_num;
      map_wide_q <= top_seg || (seg.dx == TOP_DX);
      seg_base_q <= top_seg ? TOP_Y : seg.y0;
    end
    if (cmd_i.commit_map) begin
      if (sts_o.raw_small) begin
        metric_q <= '0;
      end else begin
        metric_q <= (map_val > 21'(SPEED_MAX)) ? SPEED_MAX : map_val[7:0];
      end
    end
  end

  // Output register.
  assign mph_prod = 24'(metric_q * MPH_FACTOR) + 24'h008000;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      shown_speed_o <= imperial_q ? mph_prod[23:16] : metric_q;
      metric_speed_o <= metric_q;
      trip_tenths_o <= trip_q;
      odo_km_o <= odo_q;
      save_strobe_o <= save_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller.
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign sts_o.den_zero = den_q == '0;
  assign sts_o.raw_small = raw_q < 16'd2;
  assign sts_o.out_blocked = out_valid_q && out_stall_i;

endmodule

// ===== design/speedometer_odometer_tick.sv =====
`timescale 1ns / 1ps
// Flow: after a tick is accepted, the distance update, the 37-step speed division and the map
// run in turn before the result beat; a raw speed below 2 skips the map division.
// Pulses per rev of zero skips both divisions. Ticks: one result per tick; the next tick is
// taken only once the result is loaded, and a stalled result holds back the load of the next one.
// Reset: asynchronous, active low; clears the window, the distance counters and the
// previous sample, and loads the configuration reset values.
module speedometer_odometer_tick import spdo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pulse_total_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  shown_speed_o,
  output logic [7:0]  metric_speed_o,
  output logic [15:0] trip_tenths_o,
  output logic [23:0] odo_km_o,
  output logic        save_strobe_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  spdo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spdo_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pulse_total_i  (pulse_total_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .shown_speed_o  (shown_speed_o),
    .metric_speed_o (metric_speed_o),
    .trip_tenths_o  (trip_tenths_o),
    .odo_km_o       (odo_km_o),
    .save_strobe_o  (save_strobe_o)
  );

endmodule
